/* hdl/kvi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvi_pkg
// Shared constants, types and helpers of the keyframe vector interpolator.
// ----------------------------------------------------------------------------
package kvi_pkg;

    localparam int KEYS        = 256;
    localparam int KEY_W       = $clog2(KEYS);
    localparam int BANK_W      = KEY_W - 1;
    localparam int BANK_DEPTH  = KEYS / 2;
    localparam int COMPS       = 3;
    localparam int SLOTS       = 3;
    localparam int WORDS       = SLOTS * COMPS;
    localparam int WSEL_W      = 4;
    localparam int WORD_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int TS_W        = 31;

    localparam int NUM_W       = WORD_W + 1;
    localparam int REM_W       = NUM_W + FRAC_W;
    localparam int U_BITS      = 21;
    localparam int U_W         = U_BITS + 1;
    localparam int CMP_W       = NUM_W + U_BITS;

    localparam int PM_W        = 2 * WORD_W;
    localparam int T2P_W       = 2 * U_W;
    localparam int T2_W        = T2P_W - FRAC_W;
    localparam int T3P_W       = T2_W + U_W;
    localparam int OP_W        = NUM_W;
    localparam int WIDE_W      = 2 * OP_W;
    localparam int TERMS       = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [1:0] MODE_TIME     = 2'd0;
    localparam logic [1:0] MODE_WORD     = 2'd1;
    localparam logic [1:0] MODE_EVAL     = 2'd2;

    localparam logic [1:0] INTERP_LINEAR = 2'd0;
    localparam logic [1:0] INTERP_STEP   = 2'd1;
    localparam logic [1:0] INTERP_CUBIC  = 2'd2;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_ZERO    = 2'd1;
    localparam logic [1:0] FAULT_RANGE   = 2'd2;

    localparam logic [1:0] SLOT_IN       = 2'd0;
    localparam logic [1:0] SLOT_VAL      = 2'd1;
    localparam logic [1:0] SLOT_OUT      = 2'd2;

    localparam int WBASE_IN  = int'(SLOT_IN) * COMPS;
    localparam int WBASE_VAL = int'(SLOT_VAL) * COMPS;
    localparam int WBASE_OUT = int'(SLOT_OUT) * COMPS;

    localparam logic [0:0] REG_INTERP = 1'b0;

    localparam logic [U_BITS-1:0] U_LIM_Q = {1'b1, {(U_BITS-1){1'b0}}};

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t [COMPS-1:0] vec_t;

    typedef struct packed {
        word_t            t0;
        word_t            t1;
        logic [TS_W-1:0]  ts;
        vec_t             p0;
        vec_t             p1;
        vec_t             m0;
        vec_t             m1;
        logic             last_key;
    } eval_t;

    typedef struct packed {
        logic [U_BITS-1:0] q;
        logic              ovf;
        logic              neg;
        logic              dz;
    } div_res_t;

    function automatic word_t sat_word(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        word_t r;
        hi = {{(WIDE_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            r = {1'b0, {(WORD_W-1){1'b1}}};
        end else if (x < lo) begin
            r = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            r = x[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/keyframe_vector_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_vector_interpolator
// Keyframe store with linear, step and cubic Hermite evaluation of a
// 3-component Q16.16 vector; configuration over an APB-style port.
// Path: an evaluate passes the front read registers, the queue, the divider
//   for the normalized time and the multiply stages of the back end.
// Throughput: one transfer per cycle while s_ready; loads and evaluates alike.
// Reset: synchronous active-low; clears interp_mode, queue and pipeline valids.
//   The keyframe store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module keyframe_vector_interpolator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kvi_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [kvi_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [kvi_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_mode,
    input  logic [kvi_pkg::KEY_W-1:0]       s_key_index,
    input  logic [1:0]                      s_component,
    input  logic [1:0]                      s_slot,
    input  logic signed [31:0]              s_load_data,
    input  logic [kvi_pkg::TS_W-1:0]        s_sample_time,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [31:0]              m_out_x,
    output logic signed [31:0]              m_out_y,
    output logic signed [31:0]              m_out_z,
    output logic [1:0]                      m_fault
);
    import kvi_pkg::*;

    logic [1:0]        interp_mode_reg;
    logic [QCNT_W-1:0] queue_count;
    logic              push;
    eval_t             push_data;
    logic              pop_valid;
    eval_t             pop_data;
    logic              en;
    logic              div_valid;
    eval_t             div_pay;
    div_res_t          div_res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INTERP) ? CFG_DATA_W'(interp_mode_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interp_mode_reg <= INTERP_LINEAR;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_INTERP)) begin
            interp_mode_reg <= pwdata[1:0];
        end
    end

    kvi_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_key_index   (s_key_index),
        .s_component   (s_component),
        .s_slot        (s_slot),
        .s_load_data   (s_load_data),
        .s_sample_time (s_sample_time),
        .queue_count   (queue_count),
        .push          (push),
        .push_data     (push_data)
    );

    kvi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (en),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .count     (queue_count)
    );

    kvi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pop_valid),
        .in_pay    (pop_data),
        .out_valid (div_valid),
        .out_pay   (div_pay),
        .out_res   (div_res)
    );

    kvi_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .interp_mode (interp_mode_reg),
        .div_valid   (div_valid),
        .div_pay     (div_pay),
        .div_res     (div_res),
        .en          (en),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_z     (m_out_z),
        .m_fault     (m_fault)
    );

endmodule

/* hdl/kvi_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvi_front
// Input side: takes transfers, writes the keyframe store, and reads both keys
// of an evaluated interval from even/odd banks for the queue.
// ----------------------------------------------------------------------------
module kvi_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic [kvi_pkg::KEY_W-1:0]   s_key_index,
    input  logic [1:0]                  s_component,
    input  logic [1:0]                  s_slot,
    input  logic signed [31:0]          s_load_data,
    input  logic [kvi_pkg::TS_W-1:0]    s_sample_time,
    input  logic [kvi_pkg::QCNT_W-1:0]  queue_count,
    output logic                        push,
    output kvi_pkg::eval_t              push_data
);
    import kvi_pkg::*;

    logic                accept;
    logic                is_eval;
    logic                time_we;
    logic                word_we;
    logic [WSEL_W-1:0]   word_sel;
    logic [KEY_W-1:0]    key_next;
    logic [BANK_W-1:0]   even_addr;
    logic [BANK_W-1:0]   odd_addr;

    logic [WORD_W-1:0]   time_even [BANK_DEPTH];
    logic [WORD_W-1:0]   time_odd  [BANK_DEPTH];
    logic [WORD_W-1:0]   time_even_rd_reg;
    logic [WORD_W-1:0]   time_odd_rd_reg;
    logic [WORD_W-1:0]   word_even_rd_reg [WORDS];
    logic [WORD_W-1:0]   word_odd_rd_reg  [WORDS];

    logic                s1_valid_reg;
    logic                s1_odd_reg;
    logic                s1_last_reg;
    logic [TS_W-1:0]     s1_ts_reg;

    assign s_ready = ({1'b0, queue_count} + {{QCNT_W{1'b0}}, s1_valid_reg})
                     < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept  = s_valid & s_ready;
    assign is_eval = accept && (s_mode == MODE_EVAL);
    assign time_we = accept && (s_mode == MODE_TIME);
    assign word_we = accept && (s_mode == MODE_WORD) && (s_slot < 2'(SLOTS))
                     && (s_component < 2'(COMPS));
    assign word_sel  = WSEL_W'(s_slot) * WSEL_W'(COMPS) + WSEL_W'(s_component);
    assign key_next  = s_key_index + 1'b1;
    assign even_addr = time_we || word_we ? s_key_index[KEY_W-1:1] : key_next[KEY_W-1:1];
    assign odd_addr  = s_key_index[KEY_W-1:1];

    // time banks
    always_ff @(posedge aclk) begin
        if (time_we && !s_key_index[0]) begin
            time_even[even_addr] <= s_load_data;
        end
        if (time_we && s_key_index[0]) begin
            time_odd[odd_addr] <= s_load_data;
        end
        if (is_eval) begin
            time_even_rd_reg <= time_even[even_addr];
            time_odd_rd_reg  <= time_odd[odd_addr];
        end
    end

    // one word bank pair per slot and component
    for (genvar w = 0; w < WORDS; w++) begin : g_word
        logic [WORD_W-1:0] even_mem [BANK_DEPTH];
        logic [WORD_W-1:0] odd_mem  [BANK_DEPTH];
        logic              we;

        assign we = word_we && (word_sel == WSEL_W'(w));

        always_ff @(posedge aclk) begin
            if (we && !s_key_index[0]) begin
                even_mem[even_addr] <= s_load_data;
            end
            if (we && s_key_index[0]) begin
                odd_mem[odd_addr] <= s_load_data;
            end
            if (is_eval) begin
                word_even_rd_reg[w] <= even_mem[even_addr];
                word_odd_rd_reg[w]  <= odd_mem[odd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= is_eval;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_eval) begin
            s1_odd_reg  <= s_key_index[0];
            s1_last_reg <= (s_key_index == KEY_W'(KEYS - 1));
            s1_ts_reg   <= s_sample_time;
        end
    end

    assign push = s1_valid_reg;

    // key k sits in the odd bank when k is odd, key k+1 in the other one
    always_comb begin
        push_data.t0       = s1_odd_reg ? time_odd_rd_reg  : time_even_rd_reg;
        push_data.t1       = s1_odd_reg ? time_even_rd_reg : time_odd_rd_reg;
        push_data.ts       = s1_ts_reg;
        push_data.last_key = s1_last_reg;
        for (int c = 0; c < COMPS; c++) begin
            push_data.p0[c] = s1_odd_reg ? word_odd_rd_reg[WBASE_VAL + c]
                                         : word_even_rd_reg[WBASE_VAL + c];
            push_data.p1[c] = s1_odd_reg ? word_even_rd_reg[WBASE_VAL + c]
                                         : word_odd_rd_reg[WBASE_VAL + c];
            push_data.m0[c] = s1_odd_reg ? word_odd_rd_reg[WBASE_OUT + c]
                                         : word_even_rd_reg[WBASE_OUT + c];
            push_data.m1[c] = s1_odd_reg ? word_even_rd_reg[WBASE_IN + c]
                                         : word_odd_rd_reg[WBASE_IN + c];
        end
    end

endmodule

/* hdl/kvi_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvi_queue
// Small queue of evaluate items between the front and the divider.
// ----------------------------------------------------------------------------
module kvi_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  kvi_pkg::eval_t              push_data,
    input  logic                        pop,
    output logic                        pop_valid,
    output kvi_pkg::eval_t              pop_data,
    output logic [kvi_pkg::QCNT_W-1:0]  count
);
    import kvi_pkg::*;

    eval_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               pop_eff;

    assign pop_valid  = (count_reg != '0);
    assign pop_eff    = pop && pop_valid;
    assign pop_data   = queue_mem[rd_ptr_reg];
    assign count      = count_reg;
    assign count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_eff) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/kvi_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvi_div
// Pipelined restoring divider for the normalized time, one quotient bit per
// stage, carrying the item alongside.
// ----------------------------------------------------------------------------
module kvi_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  kvi_pkg::eval_t     in_pay,
    output logic               out_valid,
    output kvi_pkg::eval_t     out_pay,
    output kvi_pkg::div_res_t  out_res
);
    import kvi_pkg::*;

    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] den;
    logic [NUM_W-1:0]        num_mag;
    logic [NUM_W-1:0]        den_mag;
    logic [REM_W-1:0]        rem0;
    logic                    ovf0;

    logic [U_BITS:0]         v_reg;
    eval_t                   pay_reg [U_BITS+1];
    div_res_t                res_reg [U_BITS+1];
    logic [REM_W-1:0]        rem_reg [U_BITS];
    logic [NUM_W-1:0]        den_reg [U_BITS];

    always_comb begin
        num     = $signed({2'b00, in_pay.ts})
                  - $signed({in_pay.t0[WORD_W-1], in_pay.t0});
        den     = $signed({in_pay.t1[WORD_W-1], in_pay.t1})
                  - $signed({in_pay.t0[WORD_W-1], in_pay.t0});
        num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        den_mag = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
        rem0    = {num_mag, {FRAC_W{1'b0}}};
        ovf0    = CMP_W'(rem0) >= {den_mag, {U_BITS{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[U_BITS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg[0]     <= in_pay;
            rem_reg[0]     <= rem0;
            den_reg[0]     <= den_mag;
            res_reg[0].q   <= '0;
            res_reg[0].ovf <= ovf0;
            res_reg[0].neg <= num[NUM_W-1] ^ den[NUM_W-1];
            res_reg[0].dz  <= (den == '0);
        end
    end

    for (genvar s = 1; s <= U_BITS; s++) begin : g_stage
        logic [CMP_W:0] trial;
        div_res_t       res_next;

        assign trial = {1'b0, CMP_W'(rem_reg[s-1])}
                       - {1'b0, CMP_W'(den_reg[s-1]) << (U_BITS - s)};

        always_comb begin
            res_next               = res_reg[s-1];
            res_next.q[U_BITS-s]   = !trial[CMP_W];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pay_reg[s] <= pay_reg[s-1];
                res_reg[s] <= res_next;
            end
        end

        if (s < U_BITS) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s] <= trial[CMP_W] ? rem_reg[s-1] : REM_W'(trial);
                    den_reg[s] <= den_reg[s-1];
                end
            end
        end
    end

    assign out_valid = v_reg[U_BITS];
    assign out_pay   = pay_reg[U_BITS];
    assign out_res   = res_reg[U_BITS];

endmodule

/* hdl/kvi_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvi_back
// Arithmetic back end: clamps the normalized time, scales tangents, builds
// the Hermite, linear or step weights, multiplies and sums into the output register.
// ----------------------------------------------------------------------------
module kvi_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         interp_mode,
    input  logic               div_valid,
    input  kvi_pkg::eval_t     div_pay,
    input  kvi_pkg::div_res_t  div_res,
    output logic               en,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic [1:0]         m_fault
);
    import kvi_pkg::*;

    typedef enum logic [1:0] {KIND_PASS, KIND_LINEAR, KIND_CUBIC} kind_t;

    logic [4:0]               v_reg;
    logic                     m_valid_reg;

    // stage 1
    logic [U_BITS-1:0]        u_mag;
    logic signed [U_W-1:0]    u_e1;
    logic signed [NUM_W-1:0]  d_e1;
    word_t                    ds_e1;
    logic [1:0]               fault_e1;
    kind_t                    kind_e1;
    logic signed [U_W-1:0]    u1_reg;
    kind_t                    kind1_reg;
    logic [1:0]               fault1_reg;
    vec_t                     p0_1_reg;
    vec_t                     p1_1_reg;
    logic signed [PM_W-1:0]   pm0_reg [COMPS];
    logic signed [PM_W-1:0]   pm1_reg [COMPS];

    // stage 2
    logic signed [T2P_W-1:0]  sq_e2;
    logic signed [U_W-1:0]    u2_reg;
    logic signed [T2_W-1:0]   t2_2_reg;
    kind_t                    kind2_reg;
    logic [1:0]               fault2_reg;
    vec_t                     p0_2_reg;
    vec_t                     p1_2_reg;
    word_t                    m0_2_reg [COMPS];
    word_t                    m1_2_reg [COMPS];

    // stage 3
    logic signed [T3P_W-1:0]  cu_e3;
    logic signed [U_W-1:0]    u3_reg;
    logic signed [T2_W-1:0]   t2_3_reg;
    word_t                    t3_3_reg;
    kind_t                    kind3_reg;
    logic [1:0]               fault3_reg;
    vec_t                     p0_3_reg;
    vec_t                     p1_3_reg;
    word_t                    m0_3_reg [COMPS];
    word_t                    m1_3_reg [COMPS];

    // stage 4
    logic signed [OP_W-1:0]   h00, h10, h01, h11, t2x, t3x, ux;
    logic signed [OP_W-1:0]   a_e4 [COMPS][TERMS];
    logic signed [OP_W-1:0]   b_e4 [COMPS][TERMS];
    logic signed [OP_W-1:0]   a4_reg [COMPS][TERMS];
    logic signed [OP_W-1:0]   b4_reg [COMPS][TERMS];
    logic [1:0]               fault4_reg;

    // stage 5
    logic signed [WIDE_W-1:0] prod5_reg [COMPS][TERMS];
    logic [1:0]               fault5_reg;

    // stage 6
    logic signed [WIDE_W-1:0] acc [COMPS];
    word_t                    out_reg [COMPS];
    logic [1:0]               fault_reg;

    localparam logic signed [OP_W-1:0] ONE_Q = OP_W'(1) <<< FRAC_W;

    assign en      = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_out_x = out_reg[0];
    assign m_out_y = out_reg[1];
    assign m_out_z = out_reg[2];
    assign m_fault = fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg       <= {v_reg[3:0], div_valid};
            m_valid_reg <= v_reg[4];
        end
    end

    always_comb begin
        if (div_res.ovf || (div_res.q > U_LIM_Q)) begin
            u_mag = U_LIM_Q;
        end else begin
            u_mag = div_res.q;
        end
        u_e1 = div_res.neg ? -$signed({1'b0, u_mag}) : $signed({1'b0, u_mag});
        d_e1 = $signed({div_pay.t1[WORD_W-1], div_pay.t1})
               - $signed({div_pay.t0[WORD_W-1], div_pay.t0});
        ds_e1    = sat_word(WIDE_W'(d_e1));
        fault_e1 = FAULT_NONE;
        kind_e1  = KIND_PASS;
        if (interp_mode != INTERP_STEP) begin
            if (div_pay.last_key) begin
                fault_e1 = FAULT_RANGE;
            end else if (div_res.dz) begin
                fault_e1 = FAULT_ZERO;
            end else if (interp_mode == INTERP_CUBIC) begin
                kind_e1 = KIND_CUBIC;
            end else begin
                kind_e1 = KIND_LINEAR;
                if (div_res.neg) begin
                    u_e1 = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u1_reg     <= u_e1;
            kind1_reg  <= kind_e1;
            fault1_reg <= fault_e1;
            p0_1_reg   <= div_pay.p0;
            p1_1_reg   <= div_pay.p1;
            for (int c = 0; c < COMPS; c++) begin
                pm0_reg[c] <= PM_W'(ds_e1) * PM_W'($signed(div_pay.m0[c]));
                pm1_reg[c] <= PM_W'(ds_e1) * PM_W'($signed(div_pay.m1[c]));
            end
        end
    end

    assign sq_e2 = T2P_W'(u1_reg) * T2P_W'(u1_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            u2_reg     <= u1_reg;
            t2_2_reg   <= sq_e2[T2P_W-1:FRAC_W];
            kind2_reg  <= kind1_reg;
            fault2_reg <= fault1_reg;
            p0_2_reg   <= p0_1_reg;
            p1_2_reg   <= p1_1_reg;
            for (int c = 0; c < COMPS; c++) begin
                m0_2_reg[c] <= sat_word(WIDE_W'(pm0_reg[c] >>> FRAC_W));
                m1_2_reg[c] <= sat_word(WIDE_W'(pm1_reg[c] >>> FRAC_W));
            end
        end
    end

    assign cu_e3 = T3P_W'(t2_2_reg) * T3P_W'(u2_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            u3_reg     <= u2_reg;
            t2_3_reg   <= t2_2_reg;
            t3_3_reg   <= cu_e3[FRAC_W+WORD_W-1:FRAC_W];
            kind3_reg  <= kind2_reg;
            fault3_reg <= fault2_reg;
            p0_3_reg   <= p0_2_reg;
            p1_3_reg   <= p1_2_reg;
            m0_3_reg   <= m0_2_reg;
            m1_3_reg   <= m1_2_reg;
        end
    end

    always_comb begin
        t2x = OP_W'(t2_3_reg);
        t3x = OP_W'(t3_3_reg);
        ux  = OP_W'(u3_reg);
        h00 = (t3x <<< 1) - (t2x + (t2x <<< 1)) + ONE_Q;
        h10 = t3x - (t2x <<< 1) + ux;
        h01 = (t2x + (t2x <<< 1)) - (t3x <<< 1);
        h11 = t3x - t2x;
        for (int c = 0; c < COMPS; c++) begin
            for (int j = 0; j < TERMS; j++) begin
                a_e4[c][j] = '0;
                b_e4[c][j] = '0;
            end
            case (kind3_reg)
                KIND_CUBIC: begin
                    a_e4[c][0] = h00;
                    a_e4[c][1] = h10;
                    a_e4[c][2] = h01;
                    a_e4[c][3] = h11;
                    b_e4[c][0] = OP_W'($signed(p0_3_reg[c]));
                    b_e4[c][1] = OP_W'(m0_3_reg[c]);
                    b_e4[c][2] = OP_W'($signed(p1_3_reg[c]));
                    b_e4[c][3] = OP_W'(m1_3_reg[c]);
                end
                KIND_LINEAR: begin
                    a_e4[c][0] = ONE_Q;
                    a_e4[c][1] = ux;
                    b_e4[c][0] = OP_W'($signed(p0_3_reg[c]));
                    b_e4[c][1] = OP_W'($signed(p1_3_reg[c])) - OP_W'($signed(p0_3_reg[c]));
                end
                default: begin
                    a_e4[c][0] = ONE_Q;
                    b_e4[c][0] = OP_W'($signed(p0_3_reg[c]));
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a4_reg     <= a_e4;
            b4_reg     <= b_e4;
            fault4_reg <= fault3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fault5_reg <= fault4_reg;
            for (int c = 0; c < COMPS; c++) begin
                for (int j = 0; j < TERMS; j++) begin
                    prod5_reg[c][j] <= WIDE_W'(a4_reg[c][j]) * WIDE_W'(b4_reg[c][j]);
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < COMPS; c++) begin
            acc[c] = '0;
            for (int j = 0; j < TERMS; j++) begin
                acc[c] = acc[c] + (prod5_reg[c][j] >>> FRAC_W);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fault_reg <= fault5_reg;
            for (int c = 0; c < COMPS; c++) begin
                out_reg[c] <= sat_word(acc[c]);
            end
        end
    end

endmodule

/* hdl/kvi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvi_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module kvi_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_out_x,
    input logic [1:0]         m_fault
);
    import kvi_pkg::*;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_fault_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fault == FAULT_NONE || m_fault == FAULT_ZERO
                     || m_fault == FAULT_RANGE))
        else $error("illegal fault code");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_x) && $stable(m_fault))
        else $error("result changed while stalled");

endmodule

bind keyframe_vector_interpolator kvi_checker u_kvi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_out_x (m_out_x),
    .m_fault (m_fault)
);
